FILE: design/clee_pkg.sv
package clee_pkg;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// ascii codes used by the encoder
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;

	// code point boundaries
	localparam logic [20:0] CP_CTRL_END = 21'h00020;
	localparam logic [20:0] CP_BMP_LO   = 21'h00080;
	localparam logic [20:0] CP_BMP_HI   = 21'h0FFFF;
	localparam logic [20:0] CP_SUPP_LO  = 21'h10000;

	// how the character of an item is written
	typedef enum logic [2:0] {
		K_NONE,
		K_PLAIN,
		K_ESC,
		K_HEX2,
		K_HEX4,
		K_HEX8
	} kind_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        open;
		kind_t       kind;
		logic [7:0]  letter;
		logic [20:0] value;
		logic        close;
	} desc_t;

endpackage

FILE: design/clee_front.sv
module clee_front
	import clee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [20:0] code_point,
	input  logic        has_char,
	input  logic        ends_string,
	input  logic        q_full,
	output logic        q_push,
	output desc_t       q_data
);

	logic  inside_q;
	logic  accept;
	desc_t desc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the character
	always_comb begin
		desc.open   = !inside_q;
		desc.close  = ends_string;
		desc.value  = code_point;
		desc.letter = code_point[7:0];
		desc.kind   = K_PLAIN;
		if (!has_char) begin
			desc.kind = K_NONE;
		end else begin
			case (code_point)
				21'h00: begin desc.kind = K_ESC; desc.letter = "0";  end
				21'h0D: begin desc.kind = K_ESC; desc.letter = "r";  end
				21'h0A: begin desc.kind = K_ESC; desc.letter = "n";  end
				21'h0C: begin desc.kind = K_ESC; desc.letter = "f";  end
				21'h09: begin desc.kind = K_ESC; desc.letter = "t";  end
				21'h27: begin desc.kind = K_ESC; desc.letter = "'";  end
				21'h22: begin desc.kind = K_ESC; desc.letter = 8'h22; end
				21'h5C: begin desc.kind = K_ESC; desc.letter = 8'h5C; end
				21'h3F: begin desc.kind = K_ESC; desc.letter = "?";  end
				21'h07: begin desc.kind = K_ESC; desc.letter = "a";  end
				21'h08: begin desc.kind = K_ESC; desc.letter = "b";  end
				21'h0B: begin desc.kind = K_ESC; desc.letter = "v";  end
				default: begin
					if (code_point < CP_CTRL_END) begin
						desc.kind   = K_HEX2;
						desc.letter = "X";
					end else if (code_point >= CP_BMP_LO && code_point <= CP_BMP_HI) begin
						desc.kind   = K_HEX4;
						desc.letter = "u";
					end else if (code_point >= CP_SUPP_LO) begin
						desc.kind   = K_HEX8;
						desc.letter = "U";
					end
				end
			endcase
		end
	end

	// items that make no byte are dropped here
	assign q_push = accept && (desc.open || desc.close || desc.kind != K_NONE);
	assign q_data = desc;

	// literal tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (accept) begin
			inside_q <= !ends_string;
		end
	end

endmodule

FILE: design/clee_fifo.sv
module clee_fifo
	import clee_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output desc_t head
);

	desc_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/clee_back.sv
module clee_back
	import clee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       q_empty,
	input  desc_t      q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       string_closed
);

	logic       hex_upper_q;
	logic       busy_q;
	logic [3:0] pos_q;
	desc_t      cur_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       closed_q;

	desc_t      src;
	logic [3:0] pos;
	logic [3:0] char_len;
	logic [3:0] cnt;
	logic [3:0] rel;
	logic [2:0] ndig;
	logic [2:0] nib_idx;
	logic [31:0] val32;
	logic [3:0] nib;
	logic [7:0] digit;
	logic [7:0] byte_d;
	logic       is_last;
	logic       adv;
	logic       go;

	// hex case register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_upper_q <= 1'b1;
		end else if (cfg_we) begin
			hex_upper_q <= cfg_wdata;
		end
	end

	// current item: held one or fresh from the queue head
	assign src = busy_q ? cur_q : q_head;
	assign pos = busy_q ? pos_q : 4'd0;

	// byte count of the item
	always_comb begin
		ndig = 3'd0;
		case (src.kind)
			K_HEX2:  ndig = 3'd2;
			K_HEX4:  ndig = 3'd4;
			default: ndig = 3'd0;
		endcase
		case (src.kind)
			K_NONE:  char_len = 4'd0;
			K_PLAIN: char_len = 4'd1;
			K_ESC:   char_len = 4'd2;
			K_HEX2:  char_len = 4'd4;
			K_HEX4:  char_len = 4'd6;
			K_HEX8:  char_len = 4'd10;
			default: char_len = 4'd0;
		endcase
		cnt = char_len + {3'b0, src.open} + {3'b0, src.close};
	end

	// hex digit at the current position, most significant first
	always_comb begin
		rel     = pos - {3'b0, src.open};
		nib_idx = (src.kind == K_HEX8) ? (3'd7 - (rel[2:0] - 3'd2))
			: (ndig - 3'd1 - (rel[2:0] - 3'd2));
		val32   = {11'b0, src.value};
		nib     = val32[{nib_idx, 2'b00} +: 4];
		if (nib < 4'd10) begin
			digit = CH_ZERO + {4'b0, nib};
		end else begin
			digit = (hex_upper_q ? CH_UPPER_A : CH_LOWER_A) + {4'b0, nib} - 8'd10;
		end
	end

	// byte selection
	always_comb begin
		is_last = pos == (cnt - 4'd1);
		if (src.open && pos == 4'd0) begin
			byte_d = CH_QUOTE;
		end else if (src.close && is_last) begin
			byte_d = CH_QUOTE;
		end else if (rel == 4'd0) begin
			byte_d = (src.kind == K_PLAIN) ? src.letter : CH_BACKSLASH;
		end else if (rel == 4'd1) begin
			byte_d = src.letter;
		end else begin
			byte_d = digit;
		end
	end

	assign adv   = !out_valid_q || out_ready;
	assign go    = adv && (busy_q || !q_empty);
	assign q_pop = go && !busy_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (go) begin
			busy_q <= !is_last;
			pos_q  <= pos + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q   <= byte_d;
			last_q   <= is_last;
			closed_q <= is_last && src.close;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign last_of_run   = last_q;
	assign string_closed = closed_q;

endmodule

FILE: design/c_literal_escape_encoder_top.sv
// an accepted item is written into the queue; its first byte is then loaded into the back end's output register
// throughput: one output byte per cycle while out_ready does not hold the output; an item makes 1 to 12 bytes
// items that make no byte are not queued; a 4-entry queue decouples input from output
// reset (arst_n low): queue emptied, no literal open, hex case register set to upper case
module c_literal_escape_encoder_top
	import clee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [20:0] code_point,
	input  logic        has_char,
	input  logic        ends_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        string_closed
);

	logic  q_full;
	logic  q_push;
	desc_t q_data;
	logic  q_pop;
	logic  q_empty;
	desc_t q_head;

	// accept and classify
	clee_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_point  (code_point),
		.has_char    (has_char),
		.ends_string (ends_string),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	// item queue
	clee_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// byte sequencer
	clee_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.string_closed (string_closed)
	);

endmodule
